FILE: rtl/sample_accumulate_gamma_resolve_defines.svh
// Assertion macros for the accumulation buffer block.
`ifndef SAMPLE_ACCUMULATE_GAMMA_RESOLVE_DEFINES_SVH
`define SAMPLE_ACCUMULATE_GAMMA_RESOLVE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SAGR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SAGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SAGR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SAGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/sagr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sagr_pkg
// Shared widths, constants and types for the accumulation buffer block.
// ----------------------------------------------------------------------------
package sagr_pkg;
   localparam int PixBits    = 16;
   localparam int MaxPixels  = 65536;
   localparam int SumBits    = 27;
   localparam int SampleBits = 16;
   localparam int SppBits    = 11;
   localparam int MaxSamples = 1024;
   localparam int NumCh      = 4;
   localparam int MemBits    = SumBits * NumCh;
   localparam int QuotBits   = 29; // 4*sum < 2^28, plus headroom

   localparam logic KIND_ACCUM   = 1'b0;
   localparam logic KIND_RESOLVE = 1'b1;

   typedef logic signed [SumBits-1:0] sum_type;

   // handshake to the resolve unit
   typedef struct packed {
      logic                start;
      logic [SppBits-1:0]  spp;
   } rsv_ctl_type;

   function automatic sum_type sat_add(input sum_type acc,
                                       input logic signed [SampleBits-1:0] s);
      logic signed [SumBits:0] r;
      r = {acc[SumBits-1], acc} + {{(SumBits+1-SampleBits){s[SampleBits-1]}}, s};
      if (r[SumBits] != r[SumBits-1])
         sat_add = r[SumBits] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
      else
         sat_add = r[SumBits-1:0];
   endfunction
endpackage

FILE: rtl/sagr_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sagr_store
// Pixel sum memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sagr_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [sagr_pkg::PixBits-1:0]  wr_addr,
   input  logic [sagr_pkg::MemBits-1:0]  wr_data,
   input  logic [sagr_pkg::PixBits-1:0]  rd_addr,
   output logic [sagr_pkg::MemBits-1:0]  rd_data
);
   logic [sagr_pkg::MemBits-1:0] mem [sagr_pkg::MaxPixels];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/sagr_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sagr_resolve
// Shared bit-serial divider and 8-step square root for the four channels.
// ----------------------------------------------------------------------------
module sagr_resolve (
   input  logic                               clock,
   input  logic                               reset,
   input  sagr_pkg::rsv_ctl_type              ctl,
   input  logic [sagr_pkg::MemBits-1:0]       sums,
   output logic                               done,
   output logic [4*8-1:0]                     bytes_out
);
   typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT, S_NEXT} st_type;

   localparam int QB = sagr_pkg::QuotBits;
   localparam int SB = sagr_pkg::SppBits;

   st_type                       st_ff;
   logic [1:0]                   ch_ff;
   logic [4:0]                   cnt_ff;
   logic [sagr_pkg::MemBits-1:0] sums_ff;
   logic [SB-1:0]                div_ff;
   logic [QB-1:0]                quo_ff;
   logic [SB:0]                  rem_ff;
   logic [7:0]                   root_ff;
   logic [4*8-1:0]               bytes_ff;
   logic                         done_ff;

   sagr_pkg::sum_type            cur_sum;
   logic [SB:0]                  rem_sh;
   logic [8:0]                   trial;
   logic [17:0]                  trial_sq;
   logic [7:0]                   root_fin;
   logic [7:0]                   byte_val;

   always_comb begin
      cur_sum  = sums_ff[ch_ff*sagr_pkg::SumBits +: sagr_pkg::SumBits];
      rem_sh   = {rem_ff[SB-1:0], quo_ff[QB-1]};
      trial    = {1'b0, root_ff} | (9'd1 << cnt_ff[2:0]);
      trial_sq = trial * trial;
      // root including the bit decided this cycle
      root_fin = ({11'd0, trial_sq} <= quo_ff) ? trial[7:0] : root_ff;
      if (cur_sum[sagr_pkg::SumBits-1] || cur_sum == '0)
         byte_val = 8'd0;
      else if (quo_ff >= QB'(65536))
         byte_val = 8'd255;
      else
         byte_val = root_fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (st_ff == S_SQRT) && (cnt_ff == '0) && (ch_ff == 2'd3);
         case (st_ff)
            S_IDLE: begin
               if (ctl.start) begin
                  sums_ff <= sums;
                  div_ff  <= (ctl.spp == '0) ? SB'(1) :
                             (ctl.spp > SB'(sagr_pkg::MaxSamples)) ?
                             SB'(sagr_pkg::MaxSamples) : ctl.spp;
                  ch_ff   <= 2'd0;
                  st_ff   <= S_NEXT;
               end
            end
            S_NEXT: begin
               // load dividend 4*sum (negative sums yield 0 later anyway)
               quo_ff <= QB'({cur_sum[sagr_pkg::SumBits-2:0], 2'b00}) &
                         {QB{~cur_sum[sagr_pkg::SumBits-1]}};
               rem_ff <= '0;
               cnt_ff <= 5'(QB - 1);
               st_ff  <= S_DIV;
            end
            S_DIV: begin
               if (rem_sh >= {1'b0, div_ff}) begin
                  rem_ff <= rem_sh - {1'b0, div_ff};
                  quo_ff <= {quo_ff[QB-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[QB-2:0], 1'b0};
               end
               if (cnt_ff == '0) begin
                  cnt_ff  <= 5'd7;
                  root_ff <= '0;
                  st_ff   <= S_SQRT;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            S_SQRT: begin
               if ({11'd0, trial_sq} <= quo_ff)
                  root_ff <= trial[7:0];
               if (cnt_ff == '0) begin
                  // last root bit is in: store the byte, move to next channel or go idle after the last
                  bytes_ff[ch_ff*8 +: 8] <= byte_val;
                  if (ch_ff == 2'd3) begin
                     st_ff <= S_IDLE;
                  end else begin
                     ch_ff <= ch_ff + 2'd1;
                     st_ff <= S_NEXT;
                  end
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign done      = done_ff;
   assign bytes_out = bytes_ff;
endmodule

FILE: rtl/sample_accumulate_gamma_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_accumulate_gamma_resolve
// Per-pixel four-channel sum buffer with gamma-2 byte resolve.
// ----------------------------------------------------------------------------
// channel  dir  ports                     handshake
// req      in   req_kind .. req_sample_*  start & !busy
// rsp      out  rsp_* fields              rsp_valid, one cycle, no stall
// csr      in   csr_samples_per_pixel     csr_write_en
//
// Accumulate: read, registered data, add and write back.
// Resolve: busy from the accept through a dividend load, divide and root
// pass per channel; rsp_valid is high in the cycle busy drops.
// After reset a clearing pass writes zero to all 65536 entries, one a
// cycle; busy stays high meanwhile. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "sample_accumulate_gamma_resolve_defines.svh"
module sample_accumulate_gamma_resolve (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [sagr_pkg::PixBits-1:0]        req_pixel_index,
   input  logic signed [sagr_pkg::SampleBits-1:0] req_sample_red,
   input  logic signed [sagr_pkg::SampleBits-1:0] req_sample_green,
   input  logic signed [sagr_pkg::SampleBits-1:0] req_sample_blue,
   input  logic signed [sagr_pkg::SampleBits-1:0] req_sample_alpha,
   output logic                                rsp_valid,
   output logic [sagr_pkg::PixBits-1:0]        rsp_out_pixel_index,
   output logic [7:0]                          rsp_byte_red,
   output logic [7:0]                          rsp_byte_green,
   output logic [7:0]                          rsp_byte_blue,
   output logic [7:0]                          rsp_byte_alpha,
   input  logic                                csr_write_en,
   input  logic [sagr_pkg::SppBits-1:0]        csr_samples_per_pixel
);
   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_MOD, S_RESOLVE} st_type;

   localparam int SB = sagr_pkg::SumBits;

   st_type                        st_ff;
   logic [sagr_pkg::PixBits-1:0]  clr_ff;      // pass ends at the last entry
   logic [sagr_pkg::SppBits-1:0]  spp_ff;
   logic                          kind_ff;
   logic [sagr_pkg::PixBits-1:0]  pix_ff;
   logic [4*sagr_pkg::SampleBits-1:0] smp_ff;
   logic                          rsp_valid_ff;
   logic [sagr_pkg::PixBits-1:0]  rsp_pix_ff;
   logic [31:0]                   rsp_bytes_ff;

   logic                          wr_en;
   logic [sagr_pkg::PixBits-1:0]  wr_addr;
   logic [sagr_pkg::MemBits-1:0]  wr_data;
   logic [sagr_pkg::MemBits-1:0]  rd_data;
   logic [sagr_pkg::MemBits-1:0]  acc_data;
   sagr_pkg::rsv_ctl_type         rsv_ctl;
   logic                          rsv_done;
   logic [31:0]                   rsv_bytes;
   logic                          accept;

   assign accept = start && !busy;
   assign busy   = (st_ff != S_IDLE);

   // saturating add of the four samples onto the stored sums
   always_comb begin
      for (int c = 0; c < sagr_pkg::NumCh; c++) begin
         acc_data[c*SB +: SB] = sagr_pkg::sat_add(rd_data[c*SB +: SB],
            smp_ff[c*sagr_pkg::SampleBits +: sagr_pkg::SampleBits]);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pix_ff;
      wr_data = '0;
      if (st_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (st_ff == S_MOD) begin
         wr_en   = 1'b1;
         wr_data = (kind_ff == sagr_pkg::KIND_ACCUM) ? acc_data : '0;
      end
      rsv_ctl.start = (st_ff == S_MOD) && (kind_ff == sagr_pkg::KIND_RESOLVE);
      rsv_ctl.spp   = spp_ff;
   end

   sagr_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pix_ff),
      .rd_data (rd_data)
   );

   sagr_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rsv_ctl),
      .sums      (rd_data),
      .done      (rsv_done),
      .bytes_out (rsv_bytes)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_CLEAR;
         clr_ff       <= '0;
         spp_ff       <= sagr_pkg::SppBits'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (st_ff == S_RESOLVE) && rsv_done;
         if (csr_write_en)
            spp_ff <= csr_samples_per_pixel;
         case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + sagr_pkg::PixBits'(1);
               if (clr_ff == '1)
                  st_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  kind_ff <= req_kind;
                  pix_ff  <= req_pixel_index;
                  smp_ff  <= {req_sample_alpha, req_sample_blue,
                              req_sample_green, req_sample_red};
                  st_ff   <= S_READ;
               end
            end
            S_READ: st_ff <= S_MOD;   // memory read in flight
            S_MOD: begin
               st_ff <= (kind_ff == sagr_pkg::KIND_RESOLVE) ? S_RESOLVE : S_IDLE;
            end
            S_RESOLVE: begin
               if (rsv_done) begin
                  rsp_pix_ff   <= pix_ff;
                  rsp_bytes_ff <= rsv_bytes;
                  st_ff        <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_pixel_index = rsp_pix_ff;
   assign rsp_byte_red        = rsp_bytes_ff[7:0];
   assign rsp_byte_green      = rsp_bytes_ff[15:8];
   assign rsp_byte_blue       = rsp_bytes_ff[23:16];
   assign rsp_byte_alpha      = rsp_bytes_ff[31:24];

   `SAGR_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy low after accept")
   `SAGR_ASSERT_IMP(a_rsp_only_resolve, clock, reset, rsp_valid,
      !busy && kind_ff == sagr_pkg::KIND_RESOLVE, "response without resolve")
   `SAGR_ASSERT_IMP(a_done_in_resolve, clock, reset, rsv_done,
      st_ff == S_RESOLVE, "resolve unit done out of turn")
endmodule

FILE: bench/sagr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sagr_checker
// Watches the request, config and response ports of the accumulation buffer,
// keeps its own copy of the per-pixel sums and the divisor, predicts every
// resolve and compares each response field by field.
// ----------------------------------------------------------------------------
module sagr_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic                                   req_kind,
   input  logic [sagr_pkg::PixBits-1:0]           req_pixel_index,
   input  logic signed [sagr_pkg::SampleBits-1:0] req_sample_red,
   input  logic signed [sagr_pkg::SampleBits-1:0] req_sample_green,
   input  logic signed [sagr_pkg::SampleBits-1:0] req_sample_blue,
   input  logic signed [sagr_pkg::SampleBits-1:0] req_sample_alpha,
   input  logic                                   rsp_valid,
   input  logic [sagr_pkg::PixBits-1:0]           rsp_out_pixel_index,
   input  logic [7:0]                             rsp_byte_red,
   input  logic [7:0]                             rsp_byte_green,
   input  logic [7:0]                             rsp_byte_blue,
   input  logic [7:0]                             rsp_byte_alpha,
   input  logic                                   csr_write_en,
   input  logic [sagr_pkg::SppBits-1:0]           csr_samples_per_pixel,
   output int                                     mismatch_count,
   output int                                     pending_pixels
);
   localparam int SumHi = (1 << (sagr_pkg::SumBits - 1)) - 1;
   localparam int SumLo = -(1 << (sagr_pkg::SumBits - 1));

   typedef struct {
      logic [sagr_pkg::PixBits-1:0] pix;
      logic [7:0]                   ch [sagr_pkg::NumCh];
   } pixel_bytes_type;

   int                           sums [int][sagr_pkg::NumCh];   // absent entry means all zero
   logic [sagr_pkg::SppBits-1:0] spp_reg;
   pixel_bytes_type              expected_pixels [$];

   function automatic int clip_sum(input int acc, input int s);
      int r;
      r = acc + s;
      if (r > SumHi) return SumHi;
      if (r < SumLo) return SumLo;
      return r;
   endfunction

   // average, gamma 2 and scale to 256, as isqrt(floor(4*sum/spp))
   function automatic logic [7:0] gamma_byte(input int sum, input int spp);
      longint q;
      int     r;
      if (sum <= 0) return 8'd0;
      q = (longint'(sum) * 4) / spp;
      if (q >= 65536) return 8'd255;
      r = 0;
      for (int b = 7; b >= 0; b--)
         if (longint'(r | (1 << b)) * (r | (1 << b)) <= q) r = r | (1 << b);
      return r[7:0];
   endfunction

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   assign pending_pixels = expected_pixels.size();

   always @(posedge clock) begin
      int              spp;
      int              p;
      int              smp [sagr_pkg::NumCh];
      pixel_bytes_type e;
      if (reset) begin
         sums.delete();
         spp_reg = 1;
         expected_pixels.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("response for pixel %0d with no resolve pending", rsp_out_pixel_index);
               mismatch_count++;
            end else begin
               e = expected_pixels.pop_front();
               check_field("out_pixel_index", e.pix, rsp_out_pixel_index);
               check_field("byte_red", e.ch[0], rsp_byte_red);
               check_field("byte_green", e.ch[1], rsp_byte_green);
               check_field("byte_blue", e.ch[2], rsp_byte_blue);
               check_field("byte_alpha", e.ch[3], rsp_byte_alpha);
            end
         end
         if (start && !busy) begin
            p = req_pixel_index;
            if (!sums.exists(p))
               for (int c = 0; c < sagr_pkg::NumCh; c++) sums[p][c] = 0;
            if (req_kind == sagr_pkg::KIND_ACCUM) begin
               smp[0] = req_sample_red;
               smp[1] = req_sample_green;
               smp[2] = req_sample_blue;
               smp[3] = req_sample_alpha;
               for (int c = 0; c < sagr_pkg::NumCh; c++)
                  sums[p][c] = clip_sum(sums[p][c], smp[c]);
            end else begin
               spp = (spp_reg == 0) ? 1 :
                     (spp_reg > sagr_pkg::MaxSamples) ? sagr_pkg::MaxSamples : spp_reg;
               e.pix = req_pixel_index;
               for (int c = 0; c < sagr_pkg::NumCh; c++) e.ch[c] = gamma_byte(sums[p][c], spp);
               expected_pixels.push_back(e);
               sums.delete(p);
            end
         end
         if (csr_write_en) spp_reg = csr_samples_per_pixel;
      end
   end
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives accumulate and resolve requests into the accumulation buffer under
// several divisor settings and idle patterns; the checker predicts and
// compares every resolved pixel.
// ----------------------------------------------------------------------------
module tb_top;
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_kind = sagr_pkg::KIND_ACCUM;
   logic [sagr_pkg::PixBits-1:0]   req_pixel_index = '0;
   logic signed [15:0]             req_sample_red = '0;
   logic signed [15:0]             req_sample_green = '0;
   logic signed [15:0]             req_sample_blue = '0;
   logic signed [15:0]             req_sample_alpha = '0;
   logic                           rsp_valid;
   logic [sagr_pkg::PixBits-1:0]   rsp_out_pixel_index;
   logic [7:0]                     rsp_byte_red, rsp_byte_green, rsp_byte_blue, rsp_byte_alpha;
   logic                           csr_write_en = 1'b0;
   logic [sagr_pkg::SppBits-1:0]   csr_samples_per_pixel = '0;
   int                             mismatch_count;
   int                             pending_pixels;
   int                             idle_pct = 0;

   // leave margin for a running resolve before divisor writes
   localparam int DrainCycles = 300;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sample_accumulate_gamma_resolve uut (.*);

   sagr_checker u_checker (.*);

   // drive one request and hold it until the block takes it
   task automatic issue(input logic kind, input logic [15:0] pix,
                        input logic [15:0] r, input logic [15:0] g,
                        input logic [15:0] b, input logic [15:0] a);
      start            <= 1'b1;
      req_kind         <= kind;
      req_pixel_index  <= pix;
      req_sample_red   <= r;
      req_sample_green <= g;
      req_sample_blue  <= b;
      req_sample_alpha <= a;
      do @(posedge clock); while (busy);
      // sender gap: start only drops when a gap actually follows
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic accumulate(input logic [15:0] pix, input logic [15:0] r,
                             input logic [15:0] g, input logic [15:0] b,
                             input logic [15:0] a);
      issue(sagr_pkg::KIND_ACCUM, pix, r, g, b, a);
   endtask

   task automatic resolve(input logic [15:0] pix);
      issue(sagr_pkg::KIND_RESOLVE, pix, 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom));
   endtask

   // divisor may only change once all resolves are out and the unit is quiet
   task automatic set_divisor(input logic [sagr_pkg::SppBits-1:0] spp);
      start <= 1'b0;
      @(posedge clock);
      wait (pending_pixels == 0);
      repeat (DrainCycles) @(posedge clock);
      csr_write_en          <= 1'b1;
      csr_samples_per_pixel <= spp;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // random sample: extremes, Q2.14 range around one, or any 16-bit value
   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         4, 5:    return 16'($urandom);
         default: return 16'($urandom_range(20000));
      endcase
   endfunction

   // pixels mostly from a small pool so sums build up before resolve
   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(9))
         0:       return 16'($urandom);
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(7));
      endcase
   endfunction

   task automatic random_phase(input int count, input int pct);
      int n;
      idle_pct = pct;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(99) < 20) resolve(rand_pixel());
         else accumulate(rand_pixel(), rand_sample(), rand_sample(), rand_sample(),
                         rand_sample());
      end
   endtask

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // block clears its store after reset with busy held high
      set_divisor(11'd1);

      // directed: field extremes, empty pixel, last pixel, negative sums
      resolve(16'd3);
      accumulate(16'd0, 16'h7FFF, 16'h8000, 16'h0000, 16'h4000);
      accumulate(16'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001);
      resolve(16'd0);
      resolve(16'd0);
      accumulate(16'hFFFF, 16'h5555, 16'hAAAA, 16'h0100, 16'h00FF);
      resolve(16'hFFFF);
      accumulate(16'h8000, 16'h0001, 16'h0002, 16'h0004, 16'h0010);
      resolve(16'h8000);

      // divisor zero behaves as one
      set_divisor(11'd0);
      accumulate(16'd5, 16'h4000, 16'h1000, 16'h0001, 16'h7FFF);
      resolve(16'd5);

      // divisor at the maximum and above it (clamped)
      set_divisor(11'd1024);
      for (n = 0; n < 4; n++) accumulate(16'd6, 16'h4000, 16'h2000, 16'h0100, 16'h7FFF);
      resolve(16'd6);
      set_divisor(11'd2047);
      for (n = 0; n < 4; n++) accumulate(16'd7, 16'h4000, 16'h2000, 16'h0100, 16'h7FFF);
      resolve(16'd7);

      // large sums of both signs, then a partial pull-back
      for (n = 0; n < 10; n++) accumulate(16'd1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      for (n = 0; n < 10; n++) accumulate(16'd1, 16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF);
      resolve(16'd1);

      // random phases across divisor settings and idle patterns
      set_divisor(11'd1);
      random_phase(160, 0);
      set_divisor(11'd3);
      random_phase(160, 73);
      set_divisor(11'd1024);
      random_phase(160, 26);
      set_divisor(11'd0);
      random_phase(150, 0);
      set_divisor(11'd2047);
      random_phase(150, 73);
      set_divisor(11'($urandom_range(2047)));
      random_phase(150, 26);

      start <= 1'b0;
      @(posedge clock);
      wait (pending_pixels == 0);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // covers the clearing pass and slow resolves
   initial begin
      #40ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
